// ===== rtl/core/pli_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_pkg
// Shared constants and types for the piecewise linear interpolator.
// ----------------------------------------------------------------------------
package pli_pkg;

	localparam int DATA_W          = 32;
	localparam int MAX_POINTS_DEF  = 16;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int INDEX_W         = 4;
	localparam int COUNT_CFG_W     = 5;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVAL  = 1'b1;

	typedef struct packed {
		logic shift;
		logic load;
	} pli_cell_ctrl_t;

endpackage

// ===== rtl/core/pli_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_cell
// One breakpoint slot of the ring; loads a written point or takes its
// neighbor's point while the ring rotates.
// ----------------------------------------------------------------------------
module pli_cell (
	input  logic                             clk,
	input  pli_pkg::pli_cell_ctrl_t          ctrl,
	input  logic signed [pli_pkg::DATA_W-1:0] nb_key,
	input  logic signed [pli_pkg::DATA_W-1:0] nb_value,
	input  logic signed [pli_pkg::DATA_W-1:0] wr_key,
	input  logic signed [pli_pkg::DATA_W-1:0] wr_value,
	output logic signed [pli_pkg::DATA_W-1:0] key,
	output logic signed [pli_pkg::DATA_W-1:0] value
);

	logic signed [pli_pkg::DATA_W-1:0] key_q;
	logic signed [pli_pkg::DATA_W-1:0] value_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			key_q   <= wr_key;
			value_q <= wr_value;
		end else if (ctrl.shift) begin
			key_q   <= nb_key;
			value_q <= nb_value;
		end
	end

	assign key   = key_q;
	assign value = value_q;

endmodule

// ===== rtl/core/pli_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_divider
// Restoring divider for the segment weight, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pli_divider #(
	parameter int FRAC_BITS = pli_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [pli_pkg::DATA_W:0]            num,
	input  logic [pli_pkg::DATA_W:0]            den,
	output logic                                done,
	output logic [FRAC_BITS:0]                  quot
);

	localparam int CW = $clog2(FRAC_BITS + 2);
	localparam int RW = pli_pkg::DATA_W + 2;

	logic [RW-1:0]        rem_q;
	logic [FRAC_BITS:0]   quot_q;
	logic [CW-1:0]        cnt_q;
	logic                 done_q;
	logic [RW-1:0]        den_ext;
	logic                 ge;
	logic [RW-1:0]        rem_nxt;

	assign den_ext = {1'b0, den};
	assign ge      = rem_q >= den_ext;
	assign rem_nxt = ge ? (rem_q - den_ext) : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CW'(FRAC_BITS + 1);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
		end else if (cnt_q != '0) begin
			rem_q  <= {rem_nxt[RW-2:0], 1'b0};
			quot_q <= {quot_q[FRAC_BITS-1:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ===== rtl/core/piecewise_linear_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator
// Breakpoint table with clamped linear interpolation in signed fixed point.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): each beat is a breakpoint write
// (operation = write) or a query (operation = evaluate). A write is taken only
// while idle and gives no result. A query gives one result beat on the output
// channel (out_valid / out_stall) with the value and the range/empty flags.
// The breakpoints live in a ring of MAX_POINTS cells. A query rotates the
// ring once, watching the head cell to find the segment. An interpolated
// query then has a one-bit-per-cycle divider form the weight, waiting for its
// done flag, then takes a multiply step and an add step; a clamped or
// empty-table query goes from the segment search straight to the result.
// The next item is taken once the result sits in the output register.
// A stalled result is held in the output register; the block takes further
// writes meanwhile, and a following query waits only to place its result.
// Reset clears the point count n_q to zero and empties the output register.
// The cfg channel (cfg_valid / cfg_ready) is always ready.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator #(
	parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF,
	parameter int FRAC_BITS  = pli_pkg::FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pli_pkg::COUNT_CFG_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 operation,
	input  logic [pli_pkg::INDEX_W-1:0]          point_index,
	input  logic signed [pli_pkg::DATA_W-1:0]    point_key,
	input  logic signed [pli_pkg::DATA_W-1:0]    point_value,
	input  logic signed [pli_pkg::DATA_W-1:0]    query_x,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [pli_pkg::DATA_W-1:0]    interpolated,
	output logic                                 out_of_range,
	output logic                                 table_empty
);

	localparam int DW = pli_pkg::DATA_W;
	localparam int KW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int NW = $clog2(MAX_POINTS + 1);
	localparam int PW = FRAC_BITS + DW + 3;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_DIV    = 3'd3;
	localparam logic [2:0] ST_MUL    = 3'd4;
	localparam logic [2:0] ST_ADD    = 3'd5;
	localparam logic [2:0] ST_EMIT   = 3'd6;

	logic [2:0]              state_q;
	logic [KW-1:0]           k_q;
	logic [NW-1:0]           n_q;
	logic                    found_q;
	logic signed [DW-1:0]    q_q;
	logic signed [DW-1:0]    first_k_q, first_v_q, last_k_q, last_v_q;
	logic signed [DW-1:0]    prev_k_q, prev_v_q;
	logic signed [DW-1:0]    seg_x0_q, seg_x1_q, seg_y0_q, seg_y1_q;
	logic signed [DW:0]      dy_q;
	logic signed [PW-1:0]    prod_s1;
	logic signed [DW-1:0]    res_val_q;
	logic                    res_oor_q, res_empty_q;
	logic                    out_valid_q;
	logic signed [DW-1:0]    out_val_q;
	logic                    out_oor_q, out_empty_q;

	logic signed [DW-1:0]    cell_key   [MAX_POINTS];
	logic signed [DW-1:0]    cell_value [MAX_POINTS];

	logic                    in_acc, wr_acc, ev_acc, out_free;
	logic                    scan_shift;
	logic signed [DW-1:0]    head_k, head_v;
	logic [NW-1:0]           k_ext, n_last;
	logic signed [DW:0]      lo_gap, hi_gap, seg_d, seg_n;
	logic                    dv_start, dv_done;
	logic [FRAC_BITS:0]      dv_quot;
	logic signed [FRAC_BITS+1:0] w_s;
	logic signed [PW-1:0]    y0_ext, shr, sum;
	logic signed [DW-1:0]    sat_val;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign wr_acc    = in_acc && (operation == pli_pkg::OP_WRITE);
	assign ev_acc    = in_acc && (operation == pli_pkg::OP_EVAL);
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	assign scan_shift = (state_q == ST_SCAN);
	assign head_k     = cell_key[0];
	assign head_v     = cell_value[0];

	genvar i;
	generate
		for (i = 0; i < MAX_POINTS; i++) begin : g_cell
			localparam int NXT = (i + 1) % MAX_POINTS;
			pli_pkg::pli_cell_ctrl_t ctrl;
			assign ctrl.shift = scan_shift;
			assign ctrl.load  = wr_acc && (32'(point_index) == i);
			pli_cell u_cell (
				.clk      (clk),
				.ctrl     (ctrl),
				.nb_key   (cell_key[NXT]),
				.nb_value (cell_value[NXT]),
				.wr_key   (point_key),
				.wr_value (point_value),
				.key      (cell_key[i]),
				.value    (cell_value[i])
			);
		end
	endgenerate

	assign k_ext  = NW'(k_q);
	assign n_last = n_q - 1'b1;

	assign lo_gap = {first_k_q[DW-1], first_k_q} - {q_q[DW-1], q_q};
	assign hi_gap = {q_q[DW-1], q_q} - {last_k_q[DW-1], last_k_q};
	assign seg_d  = {seg_x1_q[DW-1], seg_x1_q} - {seg_x0_q[DW-1], seg_x0_q};
	assign seg_n  = {q_q[DW-1], q_q} - {seg_x0_q[DW-1], seg_x0_q};

	assign dv_start = (state_q == ST_DECIDE) && (n_q != '0) && lo_gap[DW] &&
		!(hi_gap > 0) && !(seg_d <= 0);

	pli_divider #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_start),
		.num    (seg_n),
		.den    (seg_d),
		.done   (dv_done),
		.quot   (dv_quot)
	);

	assign w_s    = {1'b0, dv_quot};
	assign y0_ext = PW'(seg_y0_q);
	assign shr    = prod_s1 >>> FRAC_BITS;
	assign sum    = y0_ext + shr;

	always_comb begin
		if (sum[PW-1:DW-1] == '0 || sum[PW-1:DW-1] == '1) begin
			sat_val = sum[DW-1:0];
		end else if (sum[PW-1]) begin
			sat_val = {1'b1, {(DW-1){1'b0}}};
		end else begin
			sat_val = {1'b0, {(DW-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			found_q     <= 1'b0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				n_q <= (32'(cfg_data) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(cfg_data);
			end
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (ev_acc) begin
						state_q <= ST_SCAN;
						k_q     <= '0;
						found_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (k_q != '0 && k_ext <= n_last && !found_q &&
						(head_k >= q_q || k_ext == n_last)) begin
						found_q <= 1'b1;
					end
					if (32'(k_q) == MAX_POINTS - 1) begin
						k_q     <= '0;
						state_q <= ST_DECIDE;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_DECIDE: begin
					state_q <= dv_start ? ST_DIV : ST_EMIT;
				end
				ST_DIV: begin
					if (dv_done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ev_acc) begin
			q_q <= query_x;
		end
		if (state_q == ST_SCAN) begin
			if (k_q == '0) begin
				first_k_q <= head_k;
				first_v_q <= head_v;
			end
			if (k_ext == n_last) begin
				last_k_q <= head_k;
				last_v_q <= head_v;
			end
			if (k_q != '0 && k_ext <= n_last && !found_q &&
				(head_k >= q_q || k_ext == n_last)) begin
				seg_x0_q <= prev_k_q;
				seg_y0_q <= prev_v_q;
				seg_x1_q <= head_k;
				seg_y1_q <= head_v;
			end
			prev_k_q <= head_k;
			prev_v_q <= head_v;
		end
		if (state_q == ST_DECIDE) begin
			dy_q        <= {seg_y1_q[DW-1], seg_y1_q} - {seg_y0_q[DW-1], seg_y0_q};
			res_oor_q   <= 1'b0;
			res_empty_q <= 1'b0;
			if (n_q == '0) begin
				res_val_q   <= '0;
				res_empty_q <= 1'b1;
			end else if (!lo_gap[DW]) begin
				res_val_q <= first_v_q;
				res_oor_q <= (lo_gap > 1);
			end else if (hi_gap > 0) begin
				res_val_q <= last_v_q;
				res_oor_q <= (hi_gap > 1);
			end else begin
				res_val_q <= seg_y1_q;
			end
		end
		if (state_q == ST_MUL) begin
			prod_s1 <= w_s * dy_q;
		end
		if (state_q == ST_ADD) begin
			res_val_q <= sat_val;
		end
		if (state_q == ST_EMIT && out_free) begin
			out_val_q   <= res_val_q;
			out_oor_q   <= res_oor_q;
			out_empty_q <= res_empty_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign interpolated = out_val_q;
	assign out_of_range = out_oor_q;
	assign table_empty  = out_empty_q;

`ifndef SYNTH
	a_ring_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (k_q == '0))
		else $error("ring not back at origin while idle");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		dv_done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide phase");

	a_out_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_EMIT))
		else $error("result beat raised without a finished query");
`endif

endmodule

// ===== bench/tb_piecewise_linear_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_piecewise_linear_interpolator
// Self-checking bench for the breakpoint table and linear interpolator.
// ----------------------------------------------------------------------------
// A queue of breakpoint writes and queries feeds a driver that idles at
// random. Each accepted beat goes through a local model of the table, and each
// query pushes its predicted value and flags. The monitor, stalling at random,
// checks every result beat against the oldest prediction. Phases change the
// point count, with the table written before any slot in use is read.
// ----------------------------------------------------------------------------
module tb_piecewise_linear_interpolator;

	typedef struct {
		logic                        op;
		logic [pli_pkg::INDEX_W-1:0] idx;
		logic signed [31:0]          key;
		logic signed [31:0]          val;
		logic signed [31:0]          qx;
	} lookup_req_t;

	typedef struct {
		logic signed [31:0] y;
		logic               oor;
		logic               empty;
	} lookup_res_t;

	localparam int QUERY_LATENCY = pli_pkg::MAX_POINTS_DEF + pli_pkg::FRAC_BITS_DEF + 6;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [pli_pkg::COUNT_CFG_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic operation;
	logic [pli_pkg::INDEX_W-1:0] point_index;
	logic signed [31:0] point_key;
	logic signed [31:0] point_value;
	logic signed [31:0] query_x;
	logic out_valid;
	logic out_stall;
	logic signed [31:0] interpolated;
	logic out_of_range;
	logic table_empty;

	lookup_req_t pending_beats[$];
	lookup_res_t expected_results[$];
	lookup_req_t cur_beat;
	logic signed [31:0] bp_keys[pli_pkg::MAX_POINTS_DEF];
	logic signed [31:0] bp_vals[pli_pkg::MAX_POINTS_DEF];
	int  active_points;
	bit  failed;
	bit  idle_en;
	bit  in_fire;
	int  in_gap;
	int  stall_left;

	piecewise_linear_interpolator u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .point_index(point_index), .point_key(point_key),
		.point_value(point_value), .query_x(query_x),
		.out_valid(out_valid), .out_stall(out_stall),
		.interpolated(interpolated), .out_of_range(out_of_range),
		.table_empty(table_empty)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_en || r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic lookup_res_t predict_lookup(input logic signed [31:0] q);
		lookup_res_t r;
		int j;
		longint qq, x0, x1, y0, y1, d, p, s;
		longint w;
		r = '{32'sd0, 1'b0, 1'b0};
		qq = q;
		if (active_points == 0) begin
			r.empty = 1'b1;
			return r;
		end
		x0 = bp_keys[0];
		if (qq <= x0) begin
			r.y = bp_vals[0];
			r.oor = (x0 - qq) > 1;
			return r;
		end
		x1 = bp_keys[active_points-1];
		if (qq > x1) begin
			r.y = bp_vals[active_points-1];
			r.oor = (qq - x1) > 1;
			return r;
		end
		j = 1;
		while (j < active_points - 1 && longint'(bp_keys[j]) < qq) j++;
		x0 = bp_keys[j-1];
		x1 = bp_keys[j];
		y0 = bp_vals[j-1];
		y1 = bp_vals[j];
		d = x1 - x0;
		if (d <= 0) begin
			r.y = bp_vals[j];
			return r;
		end
		w = ((qq - x0) <<< pli_pkg::FRAC_BITS_DEF) / d;
		p = w * (y1 - y0);
		s = y0 + (p >>> pli_pkg::FRAC_BITS_DEF);
		if (s > 64'sd2147483647) s = 64'sd2147483647;
		if (s < -64'sd2147483648) s = -64'sd2147483648;
		r.y = s[31:0];
		return r;
	endfunction

	// input driver
	always @(negedge clk) begin
		lookup_req_t b;
		if (in_fire || !in_valid) begin
			if (in_gap > 0 || pending_beats.size() == 0) begin
				if (in_gap > 0) in_gap <= in_gap - 1;
				in_valid <= 1'b0;
			end else begin
				b = pending_beats.pop_front();
				cur_beat    <= b;
				operation   <= b.op;
				point_index <= b.idx;
				point_key   <= b.key;
				point_value <= b.val;
				query_x     <= b.qx;
				in_valid    <= 1'b1;
				in_gap      <= gap_len();
			end
		end
	end

	// output stall
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else begin
			stall_left <= gap_len();
			out_stall <= 1'b0;
		end
	end

	// monitor and table model
	always @(posedge clk) begin
		lookup_res_t e;
		in_fire <= in_valid && !in_stall;
		if (out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result beat with none expected: y=%0d oor=%0b empty=%0b",
					$time, interpolated, out_of_range, table_empty);
				failed = 1'b1;
			end else begin
				e = expected_results.pop_front();
				if (interpolated !== e.y || out_of_range !== e.oor || table_empty !== e.empty) begin
					$display("%0t: mismatch expected y=%0d oor=%0b empty=%0b actual y=%0d oor=%0b empty=%0b",
						$time, e.y, e.oor, e.empty, interpolated, out_of_range, table_empty);
					failed = 1'b1;
				end
			end
		end
		if (arst_n && in_valid && !in_stall) begin
			if (cur_beat.op == pli_pkg::OP_WRITE) begin
				bp_keys[cur_beat.idx] = cur_beat.key;
				bp_vals[cur_beat.idx] = cur_beat.val;
			end else begin
				expected_results.push_back(predict_lookup(cur_beat.qx));
			end
		end
	end

	task automatic add_write(input int idx, input logic signed [31:0] k,
		input logic signed [31:0] v);
		pending_beats.push_back('{pli_pkg::OP_WRITE, idx[pli_pkg::INDEX_W-1:0], k, v, $urandom()});
	endtask

	task automatic add_query(input logic signed [31:0] q);
		int unsigned r;
		r = $urandom();
		pending_beats.push_back('{pli_pkg::OP_EVAL, r[pli_pkg::INDEX_W-1:0],
			$urandom(), $urandom(), q});
	endtask

	task automatic wait_idle();
		while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (QUERY_LATENCY + 20) @(negedge clk);
	endtask

	task automatic set_points(input int n);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= n[pli_pkg::COUNT_CFG_W-1:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		active_points = (n > pli_pkg::MAX_POINTS_DEF) ? pli_pkg::MAX_POINTS_DEF : n;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// ascending keys over a small or wide span, random values; when shuffled, some slots get random keys
	task automatic load_table(input bit shuffled);
		longint k;
		int stepmax;
		stepmax = ($urandom_range(0, 1) != 0) ? 2000 : 32'h0800_0000;
		k = -64'sd2147483648 + $urandom_range(0, 32'h7fff_ffff);
		if (stepmax == 2000) k = $signed($urandom()) / 2;
		for (int i = 0; i < pli_pkg::MAX_POINTS_DEF; i++) begin
			if (shuffled && $urandom_range(0, 3) == 0) add_write(i, $urandom(), $urandom());
			else add_write(i, k[31:0], $urandom());
			k = k + $urandom_range(1, stepmax);
			if (k > 64'sd2147483647) k = 64'sd2147483647;
		end
	endtask

	task automatic random_query();
		int r, s;
		longint a, b, q;
		r = $urandom_range(0, 99);
		s = (active_points > 1) ? $urandom_range(0, active_points - 2) : 0;
		a = bp_keys[s];
		b = bp_keys[(active_points > 1) ? s + 1 : 0];
		if (active_points == 0 || r < 15) q = $signed($urandom());
		else if (r < 55) q = a + $signed($urandom_range(0, 4)) - 2;
		else if (b > a) q = a + ((longint'($urandom()) * (b - a)) >>> 32) + 1;
		else q = a;
		if (q > 64'sd2147483647) q = 64'sd2147483647;
		if (q < -64'sd2147483648) q = -64'sd2147483648;
		add_query(q[31:0]);
	endtask

	initial begin
		int cfg_vals[10] = '{31, 1, 16, 2, 17, 8, 3, 15, 0, 12};
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		operation = pli_pkg::OP_WRITE;
		point_index = '0;
		point_key = '0;
		point_value = '0;
		query_x = '0;
		out_stall = 1'b0;
		cur_beat = '{pli_pkg::OP_WRITE, '0, '0, '0, '0};
		active_points = 0;
		failed = 1'b0;
		idle_en = 1'b1;
		in_fire = 1'b0;
		in_gap = 0;
		stall_left = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty table
		add_query(32'sh8000_0000);
		add_query(32'sh7fff_ffff);
		add_query(32'sd0);
		wait_idle();
		set_points(16);
		for (int i = 0; i < pli_pkg::MAX_POINTS_DEF; i++)
			add_write(i, (i == 0) ? 32'sh8000_0000 : (i == 15) ? 32'sh7fff_ffff :
				32'(i * 32'h0100_0000 - 32'h0800_0000),
				(i % 2 != 0) ? 32'sh7fff_ffff : 32'sh8000_0000);
		add_query(32'sh8000_0000);
		add_query(32'sh7fff_ffff);
		add_query(32'sh0100_0000);
		add_query(32'sh00ff_ffff);
		add_query(32'sh0100_0001);
		add_query(32'sh0080_0000);
		wait_idle();
		set_points(1);
		add_query(32'sh8000_0000);
		add_query(32'sh8000_0001);
		add_query(32'sh8000_0002);
		wait_idle();
		set_points(2);
		add_write(1, 32'sh0000_0010, 32'sh0001_0000);
		add_query(32'sh0000_0011);
		add_query(32'sh0000_0012);
		add_query(32'sh0000_0008);
		wait_idle();

		for (int ph = 0; ph < 10; ph++) begin
			idle_en = (ph % 4) != 3;
			set_points(cfg_vals[ph]);
			load_table(ph % 3 == 2);
			while (pending_beats.size() != 0) @(negedge clk);
			for (int i = 0; i < 110; i++) begin
				if ($urandom_range(0, 19) == 0) add_write($urandom_range(0, 15), $urandom(), $urandom());
				else random_query();
				if (pending_beats.size() > 4) wait (pending_beats.size() <= 4);
			end
			wait_idle();
		end

		if (failed || expected_results.size() != 0) $display("tb_piecewise_linear_interpolator NOT OK");
		else $display("tb_piecewise_linear_interpolator OK");
		$finish;
	end

	initial begin
		#3000000;
		$display("tb_piecewise_linear_interpolator NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/pli_pkg.sv
rtl/core/pli_cell.sv
rtl/core/pli_divider.sv
rtl/core/piecewise_linear_interpolator.sv
bench/tb_piecewise_linear_interpolator.sv
